// ----- rtl/core/flash_command_interface_assert.svh -----
// ----------------------------------------------------------------------------
// flash command interface assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FLASH_COMMAND_INTERFACE_ASSERT_SVH
`define FLASH_COMMAND_INTERFACE_ASSERT_SVH

// consequent in the next cycle, disabled in reset
`define FCI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("flash command interface check failed");

// consequent in the same cycle, disabled in reset
`define FCI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("flash command interface check failed");

// consequent in the next cycle, checked through reset
`define FCI_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("flash command interface reset check failed");

`endif

// ----- rtl/core/fci_pkg.sv -----
// ----------------------------------------------------------------------------
// fci_pkg
// constants and command codes of the flash command interface
// ----------------------------------------------------------------------------
package fci_pkg;

    localparam int BLOCK_ADDRESS_BITS = 16;
    localparam int PAGE_BYTES         = 256;
    localparam int DEF_MAX_BLOCKS     = 64;
    localparam int DEF_ARRAY_BYTES    = 4194304;

    // request kinds
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_WRITE_ENABLE = 3'd0;
    localparam logic [2:0] CFG_SIZE_CODE    = 3'd1;
    localparam logic [2:0] CFG_VENDOR       = 3'd2;
    localparam logic [2:0] CFG_DEVICE       = 3'd3;
    localparam logic [2:0] CFG_SERIAL       = 3'd4;

    // read modes
    localparam logic [2:0] MODE_ARRAY  = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_PAGE   = 3'd2;
    localparam logic [2:0] MODE_COMPAT = 3'd3;
    localparam logic [2:0] MODE_EXT    = 3'd4;

    // command bytes
    localparam logic [7:0] CMD_PAGE_PROGRAM  = 8'h0c;
    localparam logic [7:0] CMD_PROGRAM       = 8'h10;
    localparam logic [7:0] CMD_ERASE         = 8'h20;
    localparam logic [7:0] CMD_SIGNATURE     = 8'h38;
    localparam logic [7:0] CMD_PROGRAM_ALT   = 8'h40;
    localparam logic [7:0] CMD_CLEAR_STATUS  = 8'h50;
    localparam logic [7:0] CMD_READ_COMPAT   = 8'h70;
    localparam logic [7:0] CMD_READ_EXT      = 8'h71;
    localparam logic [7:0] CMD_SWAP_PAGE     = 8'h72;
    localparam logic [7:0] CMD_LOAD_BYTE     = 8'h74;
    localparam logic [7:0] CMD_READ_PAGE     = 8'h75;
    localparam logic [7:0] CMD_LOCK          = 8'h77;
    localparam logic [7:0] CMD_SLEEP         = 8'h80;
    localparam logic [7:0] CMD_READ_IDENT    = 8'h90;
    localparam logic [7:0] CMD_RB_MODE       = 8'h96;
    localparam logic [7:0] CMD_LOCK_REFRESH  = 8'h97;
    localparam logic [7:0] CMD_UPLOAD_COUNTS = 8'h99;
    localparam logic [7:0] CMD_ERASE_ALL     = 8'ha7;
    localparam logic [7:0] CMD_RESUME        = 8'hb0;
    localparam logic [7:0] CMD_CONFIRM       = 8'hd0;
    localparam logic [7:0] CMD_LOAD_SEQ      = 8'he0;
    localparam logic [7:0] CMD_SLEEP_ALT     = 8'hf0;
    localparam logic [7:0] CMD_WORD_PROGRAM  = 8'hfb;
    localparam logic [7:0] CMD_READ_ARRAY    = 8'hff;

    // data constants
    localparam logic [7:0]  ERASED_BYTE   = 8'hff;
    localparam logic [7:0]  ID_SIGNATURE  = 8'h63;
    localparam logic [7:0]  ID_FILL       = 8'h20;
    localparam logic [7:0]  SIG_BYTE0     = 8'h4d;
    localparam logic [7:0]  SIG_BYTE1     = 8'h50;
    localparam logic [7:0]  SIG_BYTE2     = 8'h04;
    localparam logic [7:0]  SIG_SIZE_BASE = 8'h10;
    localparam logic [3:0]  SIG_SIZE_OFS  = 4'd10;
    localparam logic [7:0]  UPLOAD_HDR    = 8'h06;
    localparam logic [31:0] UPLOAD_MARK   = 32'h8000_0000;
    localparam logic [47:0] SERIAL_RESET  = 48'h00_0123_456789;
    localparam logic [7:0]  VENDOR_RESET  = 8'hb0;
    localparam logic [7:0]  DEVICE_RESET  = 8'ha8;

endpackage

// ----- rtl/core/flash_command_interface.sv -----
// bus read: ST_RD_ISSUE, then ST_RD_OUT registers the result once the output is free; command
// byte: ST_DECODE; requests wait for ST_IDLE; a program byte is read in ST_PRG_RD and written in
// ST_PRG_WR, after ST_PB_ISSUE for page-buffer copies; an erase sweeps its block after the
// ST_TICK scan and counts it; after reset a clearing pass, taking no request, writes every array
// byte; reset is synchronous, active low; configuration writes are taken at any time
// ----------------------------------------------------------------------------
// flash_command_interface
// paged flash with a command history, page buffers and a small sequencer
// ----------------------------------------------------------------------------
module flash_command_interface
    import fci_pkg::*;
#(
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int ARRAY_BYTES = DEF_ARRAY_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[23:0], write_data[31:24]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_data[7:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int AW = $clog2(ARRAY_BYTES);
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam logic FITS4 = (ARRAY_BYTES >= 4194304);
    localparam logic FITS2 = (ARRAY_BYTES >= 2097152);

    // sequencer states
    typedef enum logic [14:0] {
        ST_CLEAR    = 15'h0001,
        ST_IDLE     = 15'h0002,
        ST_RD_ISSUE = 15'h0004,
        ST_RD_OUT   = 15'h0008,
        ST_DECODE   = 15'h0010,
        ST_PB_ISSUE = 15'h0020,
        ST_PRG_RD   = 15'h0040,
        ST_PRG_WR   = 15'h0080,
        ST_SIG      = 15'h0100,
        ST_UP_HDR   = 15'h0200,
        ST_UP_RD    = 15'h0400,
        ST_UP_WR    = 15'h0800,
        ST_TICK     = 15'h1000,
        ST_ERASE    = 15'h2000,
        ST_EC_WR    = 15'h4000
    } state_t;

    // which program sequence the shared byte program belongs to
    typedef enum logic [1:0] {
        PK_SINGLE,
        PK_COPY,
        PK_WORD_LO,
        PK_WORD_HI
    } pkind_t;

    state_t state_reg, state_next;

    // configuration
    logic        wep_reg, wep_next;
    logic [1:0]  size_code_reg, size_code_next;
    logic [7:0]  vendor_reg, vendor_next;
    logic [7:0]  device_reg, device_next;
    logic [47:0] serial_reg, serial_next;

    // global status
    logic       page_reg, page_next;
    logic       sleep_reg, sleep_next;
    logic       fail_reg, fail_next;    // compat write/erase failed and global failed
    logic       ready_reg, ready_next;  // compat ready and global ready
    logic [2:0] mode_reg, mode_next;

    // per-block status
    logic [MAX_BLOCKS-1:0] lock_bits_reg, lock_bits_next;
    logic [MAX_BLOCKS-1:0] locked_reg, locked_next;
    logic [MAX_BLOCKS-1:0] failed_reg, failed_next;
    logic [MAX_BLOCKS-1:0] bready_reg, bready_next;
    logic [MAX_BLOCKS-1:0] pending_reg, pending_next;
    logic [MAX_BLOCKS-1:0] ec_valid_reg, ec_valid_next;

    // command history
    logic [2:0]  hist_cnt_reg, hist_cnt_next;
    logic [23:0] hist_addr_reg [4];
    logic [23:0] hist_addr_next [4];
    logic [7:0]  hist_data_reg [4];
    logic [7:0]  hist_data_next [4];
    logic [7:0]  hd [4];
    logic [23:0] ha [4];

    // latched request address
    logic [23:0] in_addr_reg, in_addr_next;

    // sequencer work registers
    logic [23:0] wa_reg, wa_next;
    logic [15:0] wn_reg, wn_next;
    logic [15:0] wcount_reg, wcount_next;
    logic [7:0]  wval_reg, wval_next;
    logic [3:0]  wk_reg, wk_next;
    pkind_t      kind_reg, kind_next;
    logic [AW-1:0] clr_reg, clr_next;

    // result register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;

    // memories
    logic [7:0]    flash_mem [ARRAY_BYTES];
    logic [7:0]    pb_mem [2*PAGE_BYTES];
    logic [31:0]   ec_mem [MAX_BLOCKS];
    logic          fm_we;
    logic [AW-1:0] fm_addr;
    logic [7:0]    fm_wdata;
    logic [7:0]    fm_rdata_reg;
    logic          pb_we;
    logic [8:0]    pb_addr;
    logic [7:0]    pb_wdata;
    logic [7:0]    pb_rdata_reg;
    logic          ec_we;
    logic [31:0]   ec_wdata;
    logic [31:0]   ec_rdata_reg;

    // derived geometry
    logic [1:0]            sc;
    logic [BW:0]           blk_cnt;
    logic [BW-1:0]         blk_mask;
    logic [MAX_BLOCKS-1:0] cnt_vec;
    logic [6:0]            raw_cnt;
    logic [BW-1:0]         blk_cur;
    logic [BW-1:0]         blk_rd;
    logic [BW-1:0]         wn_idx;
    logic [15:0]           count_sel;
    logic [15:0]           count_dec;
    logic [31:0]           ec_val;
    logic [31:0]           up_val;
    logic [7:0]            rd_byte;
    logic [7:0]            sig_addr;
    logic [7:0]            sig_data;
    logic                  conf_ok;

    function automatic logic [BW-1:0] blk_of(input logic [23:0] a, input logic [BW-1:0] m);
        return a[BLOCK_ADDRESS_BITS +: BW] & m;
    endfunction

    function automatic logic [AW-1:0] arr_idx(input logic [BW-1:0] b, input logic [15:0] lo);
        logic [BW+15:0] t;
        t = {b, lo};
        return AW'(t);
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // size code clamped to the array that is present
    always_comb begin
        sc = (size_code_reg > 2'd2) ? 2'd2 : size_code_reg;
        if (sc == 2'd2 && !FITS4) begin
            sc = 2'd1;
        end
        if (sc == 2'd1 && !FITS2) begin
            sc = 2'd0;
        end
        raw_cnt  = 7'd16 << sc;
        blk_cnt  = (raw_cnt > 7'(MAX_BLOCKS)) ? (BW+1)'(MAX_BLOCKS) : (BW+1)'(raw_cnt);
        blk_mask = BW'(blk_cnt - 1'b1);
        for (int n = 0; n < MAX_BLOCKS; n++) begin
            cnt_vec[n] = ((BW+1)'(n) < blk_cnt);
        end
    end

    // history entries past the fill count read as zero
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            hd[i] = (3'(i) < hist_cnt_reg) ? hist_data_reg[i] : 8'd0;
            ha[i] = (3'(i) < hist_cnt_reg) ? hist_addr_reg[i] : 24'd0;
        end
    end

    assign blk_cur   = blk_of(wa_reg, blk_mask);
    assign blk_rd    = blk_of(in_addr_reg, blk_mask);
    assign wn_idx    = wn_reg[BW-1:0];
    assign count_sel = ha[1][0] ? {hd[1], hd[2]} : {hd[2], hd[1]};
    assign count_dec = {hd[2], hd[1]} - 16'd1;
    assign ec_val    = ec_valid_reg[wn_idx] ? ec_rdata_reg : 32'd1;
    assign up_val    = ec_val | UPLOAD_MARK;
    assign conf_ok   = (hd[1] == CMD_CONFIRM);

    // signature bytes: header, size code, then the serial big-endian
    always_comb begin
        case (wk_reg)
            4'd0: begin sig_addr = 8'h00; sig_data = SIG_BYTE0; end
            4'd1: begin sig_addr = 8'h02; sig_data = SIG_BYTE1; end
            4'd2: begin sig_addr = 8'h04; sig_data = SIG_BYTE2; end
            4'd3: begin
                sig_addr = 8'h06;
                sig_data = SIG_SIZE_BASE | {4'h0, SIG_SIZE_OFS + {2'b00, sc}};
            end
            4'd4: begin sig_addr = 8'h08; sig_data = serial_reg[47:40]; end
            4'd5: begin sig_addr = 8'h0a; sig_data = serial_reg[39:32]; end
            4'd6: begin sig_addr = 8'h0c; sig_data = serial_reg[31:24]; end
            4'd7: begin sig_addr = 8'h0e; sig_data = serial_reg[23:16]; end
            4'd8: begin sig_addr = 8'h10; sig_data = serial_reg[15:8]; end
            4'd9: begin sig_addr = 8'h12; sig_data = serial_reg[7:0]; end
            default: begin sig_addr = 8'h00; sig_data = 8'h00; end
        endcase
    end

    // read answer in the current mode
    always_comb begin
        case (mode_reg)
            MODE_IDENT: begin
                if (in_addr_reg == 24'd0) begin
                    rd_byte = vendor_reg;
                end else if (in_addr_reg == 24'd1) begin
                    rd_byte = device_reg;
                end else begin
                    rd_byte = (in_addr_reg[2:0] == 3'd2) ? ID_SIGNATURE : ID_FILL;
                end
            end
            MODE_PAGE:   rd_byte = pb_rdata_reg;
            MODE_COMPAT: rd_byte = {ready_reg, 1'b0, fail_reg, fail_reg, 4'h0};
            MODE_EXT: begin
                if (in_addr_reg[15:0] == 16'd2) begin
                    rd_byte = {bready_reg[blk_rd], ~locked_reg[blk_rd], failed_reg[blk_rd],
                               5'h00};
                end else if (in_addr_reg[15:0] == 16'd4) begin
                    rd_byte = {ready_reg, 1'b0, fail_reg, sleep_reg, 3'h0, page_reg};
                end else begin
                    rd_byte = 8'h00;
                end
            end
            default: rd_byte = fm_rdata_reg;
        endcase
    end

    // array port address: clearing pass, bus read, erase sweep or program
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            fm_addr = clr_reg;
        end else if (state_reg == ST_RD_ISSUE || state_reg == ST_RD_OUT) begin
            fm_addr = arr_idx(blk_rd, in_addr_reg[15:0]);
        end else if (state_reg == ST_ERASE) begin
            fm_addr = arr_idx(wn_idx, wa_reg[15:0]);
        end else begin
            fm_addr = arr_idx(blk_cur, wa_reg[15:0]);
        end
    end

    // main sequencer
    always_comb begin
        state_next     = state_reg;
        wep_next       = wep_reg;
        size_code_next = size_code_reg;
        vendor_next    = vendor_reg;
        device_next    = device_reg;
        serial_next    = serial_reg;
        page_next      = page_reg;
        sleep_next     = sleep_reg;
        fail_next      = fail_reg;
        ready_next     = ready_reg;
        mode_next      = mode_reg;
        lock_bits_next = lock_bits_reg;
        locked_next    = locked_reg;
        failed_next    = failed_reg;
        bready_next    = bready_reg;
        pending_next   = pending_reg;
        ec_valid_next  = ec_valid_reg;
        hist_cnt_next  = hist_cnt_reg;
        hist_addr_next = hist_addr_reg;
        hist_data_next = hist_data_reg;
        in_addr_next   = in_addr_reg;
        wa_next        = wa_reg;
        wn_next        = wn_reg;
        wcount_next    = wcount_reg;
        wval_next      = wval_reg;
        wk_next        = wk_reg;
        kind_next      = kind_reg;
        clr_next       = clr_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        m_data_next    = m_data_reg;
        fm_we          = 1'b0;
        fm_wdata       = fm_rdata_reg & wval_reg;
        pb_we          = 1'b0;
        pb_addr        = {page_reg, wa_reg[7:0]};
        pb_wdata       = 8'h00;
        ec_we          = 1'b0;
        ec_wdata       = ec_val + 32'd1;

        // configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_WRITE_ENABLE: wep_next       = cfg_data[0];
                CFG_SIZE_CODE:    size_code_next = cfg_data[1:0];
                CFG_VENDOR:       vendor_next    = cfg_data[7:0];
                CFG_DEVICE:       device_next    = cfg_data[7:0];
                CFG_SERIAL:       serial_next    = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR: begin
                fm_we    = 1'b1;
                fm_wdata = ERASED_BYTE;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(ARRAY_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    in_addr_next = s_tdata[23:0];
                    case (s_tuser)
                        OP_READ: state_next = ST_RD_ISSUE;
                        OP_WRITE: begin
                            // a fifth byte is dropped, the command is still decoded
                            if (hist_cnt_reg < 3'd4) begin
                                hist_addr_next[hist_cnt_reg[1:0]] = s_tdata[23:0];
                                hist_data_next[hist_cnt_reg[1:0]] = s_tdata[31:24];
                                hist_cnt_next = hist_cnt_reg + 3'd1;
                            end
                            state_next = ST_DECODE;
                        end
                        OP_TICK: begin
                            wn_next    = 16'd0;
                            state_next = ST_TICK;
                        end
                        default: ;
                    endcase
                end
            end

            ST_RD_ISSUE: begin
                pb_addr    = {page_reg, in_addr_reg[7:0]};
                state_next = ST_RD_OUT;
            end

            ST_RD_OUT: begin
                pb_addr = {page_reg, in_addr_reg[7:0]};
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_byte;
                    state_next   = ST_IDLE;
                end
            end

            ST_DECODE: begin
                state_next    = ST_IDLE;
                hist_cnt_next = 3'd0;
                case (hd[0])
                    CMD_PAGE_PROGRAM: begin
                        if (hist_cnt_reg < 3'd3) begin
                            hist_cnt_next = hist_cnt_reg;
                        end else begin
                            wcount_next = count_sel;
                            wa_next     = ha[2];
                            wn_next     = 16'd0;
                            kind_next   = PK_COPY;
                            state_next  = ST_PB_ISSUE;
                        end
                    end
                    CMD_PROGRAM, CMD_PROGRAM_ALT: begin
                        if (hist_cnt_reg < 3'd2) begin
                            hist_cnt_next = hist_cnt_reg;
                        end else begin
                            wa_next    = ha[1];
                            wval_next  = hd[1];
                            kind_next  = PK_SINGLE;
                            state_next = ST_PRG_RD;
                        end
                    end
                    CMD_WORD_PROGRAM: begin
                        if (hist_cnt_reg < 3'd3) begin
                            hist_cnt_next = hist_cnt_reg;
                        end else begin
                            wcount_next = count_sel;
                            wa_next     = ha[2];
                            wval_next   = count_sel[7:0];
                            kind_next   = PK_WORD_LO;
                            state_next  = ST_PRG_RD;
                        end
                    end
                    CMD_ERASE, CMD_SIGNATURE, CMD_LOCK, CMD_LOCK_REFRESH, CMD_UPLOAD_COUNTS,
                    CMD_ERASE_ALL, CMD_RESUME: begin
                        if (hist_cnt_reg < 3'd2) begin
                            hist_cnt_next = hist_cnt_reg;
                        end else if (!conf_ok) begin
                            // bad confirm byte
                            fail_next = 1'b1;
                        end else begin
                            case (hd[0])
                                CMD_ERASE: begin
                                    pending_next[blk_of(ha[1], blk_mask)] = 1'b1;
                                    bready_next[blk_of(ha[1], blk_mask)]  = 1'b0;
                                    ready_next = 1'b0;
                                    mode_next  = MODE_COMPAT;
                                end
                                CMD_SIGNATURE: begin
                                    wk_next    = 4'd0;
                                    state_next = ST_SIG;
                                end
                                CMD_LOCK: begin
                                    if (!wep_reg) begin
                                        failed_next[blk_of(ha[1], blk_mask)] = 1'b1;
                                        fail_next = 1'b1;
                                    end else begin
                                        lock_bits_next[blk_of(ha[1], blk_mask)] = 1'b1;
                                        locked_next[blk_of(ha[1], blk_mask)]    = 1'b1;
                                    end
                                end
                                CMD_LOCK_REFRESH: begin
                                    locked_next = (locked_reg & ~cnt_vec) |
                                                  (lock_bits_reg & cnt_vec);
                                end
                                CMD_UPLOAD_COUNTS: begin
                                    wk_next    = 4'd0;
                                    state_next = ST_UP_HDR;
                                end
                                CMD_ERASE_ALL: begin
                                    pending_next = pending_reg | cnt_vec;
                                    bready_next  = bready_reg & ~cnt_vec;
                                    ready_next   = 1'b0;
                                    mode_next    = MODE_COMPAT;
                                end
                                default: mode_next = MODE_COMPAT;
                            endcase
                        end
                    end
                    CMD_CLEAR_STATUS: begin
                        failed_next = failed_reg & ~cnt_vec;
                        fail_next   = 1'b0;
                    end
                    CMD_READ_COMPAT: mode_next = MODE_COMPAT;
                    CMD_READ_EXT:    mode_next = MODE_EXT;
                    CMD_SWAP_PAGE:   page_next = ~page_reg;
                    CMD_LOAD_BYTE: begin
                        if (hist_cnt_reg < 3'd2) begin
                            hist_cnt_next = hist_cnt_reg;
                        end else begin
                            pb_we    = 1'b1;
                            pb_addr  = {page_reg, ha[1][7:0]};
                            pb_wdata = hd[1];
                        end
                    end
                    CMD_READ_PAGE:           mode_next  = MODE_PAGE;
                    CMD_SLEEP, CMD_SLEEP_ALT: sleep_next = 1'b1;
                    CMD_READ_IDENT:          mode_next  = MODE_IDENT;
                    CMD_RB_MODE: begin
                        if (hist_cnt_reg < 3'd2) begin
                            hist_cnt_next = hist_cnt_reg;
                        end
                    end
                    CMD_LOAD_SEQ: begin
                        if (hist_cnt_reg < 3'd4) begin
                            hist_cnt_next = hist_cnt_reg;
                        end else begin
                            pb_we    = 1'b1;
                            pb_addr  = {page_reg, ha[3][7:0]};
                            pb_wdata = hd[3];
                            // more bytes to come: count down and drop the data byte
                            if ({hd[2], hd[1]} != 16'd0) begin
                                hist_data_next[1] = count_dec[7:0];
                                hist_data_next[2] = count_dec[15:8];
                                hist_cnt_next     = 3'd3;
                            end
                        end
                    end
                    CMD_READ_ARRAY: mode_next = MODE_ARRAY;
                    default: ;
                endcase
            end

            ST_PB_ISSUE: begin
                state_next = ST_PRG_RD;
            end

            ST_PRG_RD: begin
                if (kind_reg == PK_COPY) begin
                    wval_next = pb_rdata_reg;
                end
                state_next = ST_PRG_WR;
            end

            ST_PRG_WR: begin
                // locked block refuses the program unless write enable is set
                if (!wep_reg && locked_reg[blk_cur]) begin
                    failed_next[blk_cur] = 1'b1;
                    fail_next = 1'b1;
                end else begin
                    fm_we = 1'b1;
                end
                case (kind_reg)
                    PK_COPY: begin
                        if (wn_reg == wcount_reg) begin
                            page_next  = ~page_reg;
                            mode_next  = MODE_COMPAT;
                            state_next = ST_IDLE;
                        end else begin
                            wn_next    = wn_reg + 16'd1;
                            wa_next    = wa_reg + 24'd1;
                            state_next = ST_PB_ISSUE;
                        end
                    end
                    PK_WORD_LO: begin
                        wa_next    = {wa_reg[23:1], ~wa_reg[0]};
                        wval_next  = wcount_reg[15:8];
                        kind_next  = PK_WORD_HI;
                        state_next = ST_PRG_RD;
                    end
                    default: begin
                        mode_next  = MODE_COMPAT;
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_SIG: begin
                pb_we    = 1'b1;
                pb_addr  = {page_reg, sig_addr};
                pb_wdata = sig_data;
                wk_next  = wk_reg + 4'd1;
                if (wk_reg == 4'd9) begin
                    page_next  = ~page_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_UP_HDR: begin
                pb_we = 1'b1;
                if (wk_reg == 4'd0) begin
                    pb_addr  = {page_reg, 8'h06};
                    pb_wdata = UPLOAD_HDR;
                    wk_next  = 4'd1;
                end else begin
                    pb_addr    = {page_reg, 8'h07};
                    pb_wdata   = 8'h00;
                    wn_next    = 16'd0;
                    state_next = ST_UP_RD;
                end
            end

            ST_UP_RD: begin
                wk_next    = 4'd0;
                state_next = ST_UP_WR;
            end

            ST_UP_WR: begin
                pb_we    = 1'b1;
                pb_addr  = {page_reg, wn_reg[3:2], wn_reg[4], wn_reg[1:0], wn_reg[5],
                            wk_reg[1:0]};
                pb_wdata = up_val[{wk_reg[1:0], 3'b000} +: 8];
                wk_next  = wk_reg + 4'd1;
                if (wk_reg == 4'd3) begin
                    if (wn_idx == blk_mask) begin
                        page_next  = ~page_reg;
                        state_next = ST_IDLE;
                    end else begin
                        wn_next    = wn_reg + 16'd1;
                        state_next = ST_UP_RD;
                    end
                end
            end

            ST_TICK: begin
                // first pending erase starts (or is dropped if locked); blocks before it, or all, become ready
                if (pending_reg[wn_idx]) begin
                    pending_next[wn_idx] = 1'b0;
                    if (!wep_reg && locked_reg[wn_idx]) begin
                        state_next = ST_IDLE;
                    end else begin
                        wa_next    = 24'd0;
                        state_next = ST_ERASE;
                    end
                end else begin
                    bready_next[wn_idx] = 1'b1;
                    if (wn_idx == blk_mask) begin
                        ready_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        wn_next = wn_reg + 16'd1;
                    end
                end
            end

            ST_ERASE: begin
                fm_we    = 1'b1;
                fm_wdata = ERASED_BYTE;
                wa_next  = wa_reg + 24'd1;
                if (wa_reg[15:0] == 16'hffff) begin
                    state_next = ST_EC_WR;
                end
            end

            ST_EC_WR: begin
                ec_we                  = 1'b1;
                ec_valid_next[wn_idx]  = 1'b1;
                lock_bits_next[wn_idx] = 1'b0;
                locked_next[wn_idx]    = 1'b0;
                state_next             = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            wep_reg       <= 1'b0;
            size_code_reg <= 2'd0;
            vendor_reg    <= VENDOR_RESET;
            device_reg    <= DEVICE_RESET;
            serial_reg    <= SERIAL_RESET;
            page_reg      <= 1'b0;
            sleep_reg     <= 1'b0;
            fail_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            mode_reg      <= MODE_ARRAY;
            lock_bits_reg <= '1;
            locked_reg    <= '0;
            failed_reg    <= '0;
            bready_reg    <= '0;
            pending_reg   <= '0;
            ec_valid_reg  <= '0;
            hist_cnt_reg  <= 3'd0;
            clr_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wep_reg       <= wep_next;
            size_code_reg <= size_code_next;
            vendor_reg    <= vendor_next;
            device_reg    <= device_next;
            serial_reg    <= serial_next;
            page_reg      <= page_next;
            sleep_reg     <= sleep_next;
            fail_reg      <= fail_next;
            ready_reg     <= ready_next;
            mode_reg      <= mode_next;
            lock_bits_reg <= lock_bits_next;
            locked_reg    <= locked_next;
            failed_reg    <= failed_next;
            bready_reg    <= bready_next;
            pending_reg   <= pending_next;
            ec_valid_reg  <= ec_valid_next;
            hist_cnt_reg  <= hist_cnt_next;
            clr_reg       <= clr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hist_addr_reg <= hist_addr_next;
        hist_data_reg <= hist_data_next;
        in_addr_reg   <= in_addr_next;
        wa_reg        <= wa_next;
        wn_reg        <= wn_next;
        wcount_reg    <= wcount_next;
        wval_reg      <= wval_next;
        wk_reg        <= wk_next;
        kind_reg      <= kind_next;
        m_data_reg    <= m_data_next;
    end

    // flash array, one port
    always_ff @(posedge aclk) begin
        if (fm_we) begin
            flash_mem[fm_addr] <= fm_wdata;
        end
        fm_rdata_reg <= flash_mem[fm_addr];
    end

    // two page buffers
    always_ff @(posedge aclk) begin
        if (pb_we) begin
            pb_mem[pb_addr] <= pb_wdata;
        end
        pb_rdata_reg <= pb_mem[pb_addr];
    end

    // erase counters, entries without a valid bit read as one
    always_ff @(posedge aclk) begin
        if (ec_we) begin
            ec_mem[wn_idx] <= ec_wdata;
        end
        ec_rdata_reg <= ec_mem[wn_idx];
    end

endmodule

// ----- rtl/core/fci_checker.sv -----
// ----------------------------------------------------------------------------
// fci_checker
// port-level checks of the flash command interface
// ----------------------------------------------------------------------------
`include "flash_command_interface_assert.svh"

module fci_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // no result survives reset
    `FCI_ASSERT_RST(a_no_result_after_reset, !aresetn, !m_tvalid)

    // a stalled result holds
    `FCI_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a real request leaves the block busy in the next cycle
    `FCI_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready && s_tuser != 2'd3, !s_tready)

    // configuration writes never stall
    `FCI_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind flash_command_interface fci_checker u_fci_checker (.*);
